// ----- src/swmf_pkg.sv -----
// Shared constants for the sliding-window median filter: defaults, port widths, register indexes.
package swmf_pkg;

    // Default geometry and pixel depth
    localparam int DEF_WINDOW     = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    // Fixed widths of the stream payload and the register port
    localparam int PIX_PORT_W = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    // Geometry after reset, before clamping to the configured maximum
    localparam int DIM_RESET = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

endpackage

// ----- src/swmf_in_if.sv -----
// Input stream channel of the median filter: one pixel or drain marker per transfer.
interface swmf_in_if;

    logic                              valid;
    logic                              ready;
    logic [swmf_pkg::PIX_PORT_W-1:0]   pixel_in;
    logic                              drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink   (input valid, input pixel_in, input drain, output ready);

endinterface

// ----- src/swmf_out_if.sv -----
// Output stream channel of the median filter: one filtered pixel per transfer.
interface swmf_out_if;

    logic                              valid;
    logic                              ready;
    logic [swmf_pkg::PIX_PORT_W-1:0]   pixel_out;
    logic                              frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input frame_end, output ready);

endinterface

// ----- src/sliding_window_median_filter_core.sv -----
// Sliding-window median filter core: line memory, pending-pixel memory, window, sorter, queue.
// The block takes a raster image one pixel per transfer and returns each pixel replaced by the
// median of the SPAN x SPAN window of original pixels centred on it (SPAN = 2*(WINDOW/2)+1);
// pixels within WINDOW/2 of an edge pass through unchanged. It sustains one input transfer per
// clock while no register is written and the queue has room: the line memory takes one read
// and one write-back per cycle, and the median comes from a pipelined odd-even transposition
// sorter of (SPAN*SPAN+1)/2 stages. The sorter's results wait in a small queue, so input keeps
// flowing while the output side stalls. Results lag the input stream by (WINDOW/2) rows plus
// WINDOW/2 pixels; send drain items after the last pixel of a frame to push the remaining
// border pixels out, or start the next frame, which pushes them out as well.
// Writing image_width or image_height restarts the frame and drops pending results; write them
// only while the block is idle. No clearing pass is needed after reset.
module sliding_window_median_filter_core #(
    parameter int WINDOW     = swmf_pkg::DEF_WINDOW,
    parameter int MAX_WIDTH  = swmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = swmf_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = swmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    swmf_in_if.sink                            i_pix,
    swmf_out_if.source                         o_pix,
    input  logic                               i_cfg_we,
    input  logic [swmf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [swmf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PORT_W  = swmf_pkg::PIX_PORT_W;
    localparam int HALF    = WINDOW / 2;
    localparam int SPAN    = 2 * HALF + 1;
    localparam int TAPS    = SPAN * SPAN;
    localparam int MID     = TAPS / 2;
    localparam int PX_W    = (PIXEL_BITS < PORT_W) ? PIXEL_BITS : PORT_W;
    localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int FDEPTH  = HALF * MAX_WIDTH + HALF + 1;
    localparam int FP_W    = $clog2(FDEPTH);
    localparam int LINE_W  = (SPAN - 1) * PX_W;
    localparam int SORT_ST = (TAPS + 1) / 2;
    localparam int QDEPTH  = SORT_ST + 4;
    localparam int QA_W    = $clog2(QDEPTH);
    localparam int QC_W    = $clog2(QDEPTH + 1);
    localparam int W_RST   = (swmf_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : swmf_pkg::DIM_RESET;
    localparam int H_RST   = (swmf_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : swmf_pkg::DIM_RESET;

    typedef struct packed {
        logic            vld;
        logic            bord;
        logic            fend;
        logic [PX_W-1:0] bval;
    } t_side;

    // Geometry and stream position
    logic [DIM_W-1:0]  r_width,   n_width;
    logic [HGT_W-1:0]  r_height,  n_height;
    logic              cfg_hit;
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [POS_W-1:0]  r_in_pos,  n_in_pos;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [FP_W-1:0]   r_pend,    n_pend;
    logic [FP_W-1:0]   r_f_wp,    n_f_wp;
    logic [FP_W-1:0]   r_f_rp,    n_f_rp;
    logic [FP_W-1:0]   lag;

    // Input decode
    logic              in_ready;
    logic              acc;
    logic              is_pix;
    logic              push;
    logic              emit_raw;
    logic              emit;
    logic              bord;
    logic              fend;
    logic [PX_W-1:0]   pix;

    // Memories
    logic [LINE_W-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_line_q;
    logic [LINE_W-1:0] n_line_wr;
    logic [PX_W-1:0]   r_pend_mem [FDEPTH];
    logic [PX_W-1:0]   r_fifo_q;

    // Stage after the transfer
    logic              r_s1_vld;
    logic              r_s1_push;
    logic              r_s1_bord;
    logic              r_s1_fend;
    logic [COL_W-1:0]  r_s1_col;
    logic [PX_W-1:0]   r_s1_pix;

    // Window and sorter
    logic [PX_W-1:0]   r_win    [SPAN][SPAN];
    logic [PX_W-1:0]   n_col    [SPAN];
    logic [PX_W-1:0]   win_flat [TAPS];
    logic [PX_W-1:0]   srt_in   [SORT_ST][TAPS];
    logic [PX_W-1:0]   n_srt    [SORT_ST][TAPS];
    logic [PX_W-1:0]   r_srt    [SORT_ST][TAPS];
    t_side             r_sb     [SORT_ST+1];

    // Output queue
    logic [PX_W:0]     r_q_mem [QDEPTH];
    logic [QA_W-1:0]   r_q_wp;
    logic [QA_W-1:0]   r_q_rp;
    logic [QC_W-1:0]   r_q_cnt;
    logic [QC_W-1:0]   r_cred;
    logic              q_push;
    logic              q_pop;
    logic [PX_W:0]     q_head;

    // Decode register writes, clamping geometry to its legal range
    always_comb begin
        logic [31:0] cv;
        cv       = 32'(i_cfg_data);
        n_width  = r_width;
        n_height = r_height;
        cfg_hit  = 1'b0;
        if (cv < 32'd3) begin
            cv = 32'd3;
        end
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swmf_pkg::CFG_IMAGE_WIDTH: begin
                    n_width = (cv > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(cv);
                    cfg_hit = 1'b1;
                end
                swmf_pkg::CFG_IMAGE_HEIGHT: begin
                    n_height = (cv > 32'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : HGT_W'(cv);
                    cfg_hit  = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Decide acceptance and whether this transfer releases a result
    assign in_ready    = (r_cred < QC_W'(QDEPTH)) && !i_cfg_we;
    assign i_pix.ready = in_ready;
    assign acc         = i_pix.valid && in_ready;
    assign is_pix      = !i_pix.drain;
    assign push        = acc && is_pix;
    assign pix         = i_pix.pixel_in[PX_W-1:0];
    assign lag         = FP_W'(32'(r_width) * 32'(HALF) + 32'(HALF));
    assign emit_raw    = is_pix ? (32'(r_pend) >= 32'(lag))
                                : ((r_pend != '0) && (32'(r_pend) > 32'(r_in_pos)));
    assign emit        = acc && emit_raw;
    assign bord        = (32'(r_out_row) < 32'(HALF))
                      || (32'(r_out_row) >= 32'(r_height) - 32'(HALF))
                      || (32'(r_out_col) < 32'(HALF))
                      || (32'(r_out_col) >= 32'(r_width) - 32'(HALF));
    assign fend        = (32'(r_out_row) == 32'(r_height) - 32'd1)
                      && (32'(r_out_col) == 32'(r_width) - 32'd1);

    // Advance input position, output position and the pending count
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_pos  = r_in_pos;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_f_wp    = r_f_wp;
        n_f_rp    = r_f_rp;
        n_pend    = r_pend;
        if (cfg_hit) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_in_pos  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_f_rp    = r_f_wp;
            n_pend    = '0;
        end else begin
            if (push) begin
                n_f_wp = (r_f_wp == FP_W'(FDEPTH - 1)) ? '0 : r_f_wp + FP_W'(1);
                if (32'(r_in_col) == 32'(r_width) - 32'd1) begin
                    n_in_col = '0;
                    if (32'(r_in_row) == 32'(r_height) - 32'd1) begin
                        n_in_row = '0;
                        n_in_pos = '0;
                    end else begin
                        n_in_row = r_in_row + ROW_W'(1);
                        n_in_pos = r_in_pos + POS_W'(1);
                    end
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                    n_in_pos = r_in_pos + POS_W'(1);
                end
            end
            if (emit) begin
                n_f_rp = (r_f_rp == FP_W'(FDEPTH - 1)) ? '0 : r_f_rp + FP_W'(1);
                if (32'(r_out_col) == 32'(r_width) - 32'd1) begin
                    n_out_col = '0;
                    if (32'(r_out_row) == 32'(r_height) - 32'd1) begin
                        n_out_row = '0;
                    end else begin
                        n_out_row = r_out_row + ROW_W'(1);
                    end
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
            end
            n_pend = r_pend + FP_W'(push) - FP_W'(emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= DIM_W'(W_RST);
            r_height  <= HGT_W'(H_RST);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_pos  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_f_wp    <= '0;
            r_f_rp    <= '0;
            r_pend    <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_pos  <= n_in_pos;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_f_wp    <= n_f_wp;
            r_f_rp    <= n_f_rp;
            r_pend    <= n_pend;
        end
    end

    // Pending-pixel memory: store each pixel, read the oldest one still owed
    always_ff @(posedge i_clk) begin
        r_fifo_q <= r_pend_mem[r_f_rp];
        if (push) begin
            r_pend_mem[r_f_wp] <= pix;
        end
    end

    // Line memory: read the column's older rows, write back with the new pixel on top
    assign n_line_wr = {r_line_q[LINE_W-PX_W-1:0], r_s1_pix};

    always_ff @(posedge i_clk) begin
        r_line_q <= r_line_mem[r_in_col];
        if (r_s1_push) begin
            r_line_mem[r_s1_col] <= n_line_wr;
        end
    end

    // Hold the transfer's control next to the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_push <= 1'b0;
        end else begin
            r_s1_vld  <= emit;
            r_s1_push <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col  <= r_in_col;
        r_s1_pix  <= pix;
        r_s1_bord <= bord;
        r_s1_fend <= fend;
    end

    // Build the newest window column, oldest row first
    always_comb begin
        for (int k = 0; k < SPAN - 1; k++) begin
            n_col[k] = r_line_q[(SPAN-2-k)*PX_W +: PX_W];
        end
        n_col[SPAN-1] = r_s1_pix;
    end

    // Shift the window one column on every pixel
    always_ff @(posedge i_clk) begin
        if (r_s1_push) begin
            for (int c = 0; c < SPAN - 1; c++) begin
                r_win[c] <= r_win[c+1];
            end
            r_win[SPAN-1] <= n_col;
        end
    end

    for (genvar c = 0; c < SPAN; c++) begin : g_flat_c
        for (genvar r = 0; r < SPAN; r++) begin : g_flat_r
            assign win_flat[c*SPAN+r] = r_win[c][r];
        end
    end

    // Sorter: two compare-exchange layers per stage
    for (genvar s = 0; s < SORT_ST; s++) begin : g_sort
        if (s == 0) begin : g_head
            assign srt_in[s] = win_flat;
        end else begin : g_tail
            assign srt_in[s] = r_srt[s-1];
        end

        always_comb begin
            logic [PX_W-1:0] a [TAPS];
            logic [PX_W-1:0] tmp;
            a   = srt_in[s];
            tmp = '0;
            for (int k = 0; k + 1 < TAPS; k += 2) begin
                if (a[k] > a[k+1]) begin
                    tmp    = a[k];
                    a[k]   = a[k+1];
                    a[k+1] = tmp;
                end
            end
            for (int k = 1; k + 1 < TAPS; k += 2) begin
                if (a[k] > a[k+1]) begin
                    tmp    = a[k];
                    a[k]   = a[k+1];
                    a[k+1] = tmp;
                end
            end
            n_srt[s] = a;
        end

        always_ff @(posedge i_clk) begin
            r_srt[s] <= n_srt[s];
        end
    end

    // Carry result control and the border value alongside the sorter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SORT_ST; i++) begin
                r_sb[i].vld <= 1'b0;
            end
        end else begin
            r_sb[0] <= '{vld: r_s1_vld, bord: r_s1_bord, fend: r_s1_fend, bval: r_fifo_q};
            for (int i = 1; i <= SORT_ST; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    // Output queue: park finished results until the sink takes them
    assign q_push = r_sb[SORT_ST].vld;
    assign q_head = r_q_mem[r_q_rp];
    assign q_pop  = o_pix.valid && o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_mem[r_q_wp] <= {r_sb[SORT_ST].fend,
                                r_sb[SORT_ST].bord ? r_sb[SORT_ST].bval
                                                   : r_srt[SORT_ST-1][MID]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
            r_cred  <= '0;
        end else begin
            if (q_push) begin
                r_q_wp <= (r_q_wp == QA_W'(QDEPTH - 1)) ? '0 : r_q_wp + QA_W'(1);
            end
            if (q_pop) begin
                r_q_rp <= (r_q_rp == QA_W'(QDEPTH - 1)) ? '0 : r_q_rp + QA_W'(1);
            end
            r_q_cnt <= r_q_cnt + QC_W'(q_push) - QC_W'(q_pop);
            r_cred  <= r_cred + QC_W'(emit) - QC_W'(q_pop);
        end
    end

    assign o_pix.valid     = (r_q_cnt != '0);
    assign o_pix.pixel_out = PORT_W'(q_head[PX_W-1:0]);
    assign o_pix.frame_end = q_head[PX_W];

`ifndef SYNTH
    // A column read never meets the write-back of the same column
    a_line_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_push && push) |-> (r_in_col != r_s1_col))
        else $error("line memory read and write-back hit the same column");

    // Queued results never outnumber the results owed
    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= r_cred)
        else $error("output queue holds more results than were released");

    // The pending count never exceeds the window lag
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pend) <= 32'(lag))
        else $error("pending pixel count beyond the window lag");

    // A drain only releases border pixels, never a window median
    a_drain_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !is_pix) |-> bord)
        else $error("drain released an interior pixel");
`endif

endmodule
